FILE: rtl/matrix_multiply_defines.svh
// assertion macros shared by the matrix multiply checker
`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH

// same-cycle implication, sampled on clk_i, quiet during reset
`define MM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, quiet during reset
`define MM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mm_pkg.sv
// shared types and constants of the matrix multiply block
package mm_pkg;

  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned IDX_FIELD_W = 4;
  localparam int unsigned IN_ELEM_W   = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 5;
  localparam int unsigned RESULT_W    = 36;
  localparam int unsigned DIM_RESET   = 16;

  // input transaction opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_reg_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_DRAIN = 2'd2
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic issue;
    logic first_k;
    logic last_k;
    logic row_last;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic stall;
    logic busy;
  } dp_status_t;

endpackage

FILE: rtl/mm_ram.sv
// generic single-write, single-read ram with registered read data
module mm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mm_ctrl.sv
// controller: config registers, transaction decode and the row/column sequencer
module mm_ctrl #(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mm_pkg::OPCODE_W-1:0]     opcode_i,
  input  logic [mm_pkg::IDX_FIELD_W-1:0]  row_index_i,
  input  logic [mm_pkg::IDX_FIELD_W-1:0]  col_index_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mm_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [mm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output mm_pkg::dp_cmd_t                 cmd_o,
  output logic [$clog2(MAX_DIM)-1:0]      k_o,
  output logic [$clog2(MAX_DIM)-1:0]      j_o,
  input  mm_pkg::dp_status_t              status_i
);

  import mm_pkg::*;

  localparam int unsigned IDX_W     = $clog2(MAX_DIM);
  localparam int unsigned DIM_W     = $clog2(MAX_DIM + 1);
  localparam int unsigned RESET_DIM = (DIM_RESET > MAX_DIM) ? MAX_DIM : DIM_RESET;

  state_e           state_q, state_d;
  logic [DIM_W-1:0] rows_q, inner_q, cols_q;
  logic [IDX_W-1:0] k_q, k_d, j_q, j_d;
  logic             load_in_range, row_ok, k_last, j_last;

  // out-of-range dimensions saturate to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return DIM_W'(v);
    end
  endfunction

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_W'(RESET_DIM);
      inner_q <= DIM_W'(RESET_DIM);
      cols_q  <= DIM_W'(RESET_DIM);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_ROWS_A:    rows_q  <= clamp_dim(cfg_data_i);
        CFG_INNER_DIM: inner_q <= clamp_dim(cfg_data_i);
        CFG_COLS_B:    cols_q  <= clamp_dim(cfg_data_i);
        default: ;
      endcase
    end
  end

  // range checks and loop ends
  assign load_in_range = (32'(row_index_i) < MAX_DIM) && (32'(col_index_i) < MAX_DIM);
  assign row_ok        = 32'(row_index_i) < 32'(rows_q);
  assign k_last        = (32'(k_q) + 1) == 32'(inner_q);
  assign j_last        = (32'(j_q) + 1) == 32'(cols_q);

  // state and loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      j_q     <= j_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    j_d        = j_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (op_e'(opcode_i))
            OP_LOAD_A: cmd_o.load_a = load_in_range;
            OP_LOAD_B: cmd_o.load_b = load_in_range;
            OP_COMPUTE: begin
              if (row_ok) begin
                cmd_o.start = 1'b1;
                k_d         = '0;
                j_d         = '0;
                state_d     = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        // one multiply-accumulate issued per cycle unless the output is blocked
        if (!status_i.stall) begin
          cmd_o.issue    = 1'b1;
          cmd_o.first_k  = (k_q == '0);
          cmd_o.last_k   = k_last;
          cmd_o.row_last = j_last;
          if (k_last) begin
            k_d = '0;
            if (j_last) begin
              state_d = ST_DRAIN;
            end else begin
              j_d = j_q + IDX_W'(1);
            end
          end else begin
            k_d = k_q + IDX_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!status_i.busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign k_o = k_q;
  assign j_o = j_q;

endmodule

FILE: rtl/mm_datapath.sv
// datapath: operand stores, multiply-accumulate pipeline and output register
module mm_datapath #(
  parameter int unsigned MAX_DIM    = 16,
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [mm_pkg::IDX_FIELD_W-1:0]      row_index_i,
  input  logic [mm_pkg::IDX_FIELD_W-1:0]      col_index_i,
  input  logic signed [mm_pkg::IN_ELEM_W-1:0] element_value_i,
  input  mm_pkg::dp_cmd_t                     cmd_i,
  input  logic [$clog2(MAX_DIM)-1:0]          k_i,
  input  logic [$clog2(MAX_DIM)-1:0]          j_i,
  output mm_pkg::dp_status_t                  status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [mm_pkg::RESULT_W-1:0]  result_value_o,
  output logic [mm_pkg::IDX_FIELD_W-1:0]      result_row_o,
  output logic [mm_pkg::IDX_FIELD_W-1:0]      result_col_o,
  output logic                                row_last_o
);

  import mm_pkg::*;

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned PROD_W = 2 * ELEM_WIDTH;

  logic [IDX_FIELD_W-1:0]   row_q;
  logic [ADDR_W-1:0]        waddr, a_raddr, b_raddr;
  logic [ELEM_WIDTH-1:0]    wdata, a_rdata, b_rdata;
  logic                     s1_valid_q, s1_first_q, s1_last_q, s1_row_last_q;
  logic [IDX_FIELD_W-1:0]   s1_col_q;
  logic                     s2_valid_q, s2_first_q, s2_last_q, s2_row_last_q;
  logic [IDX_FIELD_W-1:0]   s2_col_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [RESULT_W-1:0]      acc_q, acc_sum;
  logic                     out_valid_q, out_row_last_q;
  logic [RESULT_W-1:0]      out_value_q;
  logic [IDX_FIELD_W-1:0]   out_row_q, out_col_q;
  logic                     stall, out_load;

  // store addresses, row-major
  assign waddr   = ADDR_W'(32'(row_index_i) * MAX_DIM + 32'(col_index_i));
  assign a_raddr = ADDR_W'(32'(row_q) * MAX_DIM + 32'(k_i));
  assign b_raddr = ADDR_W'(32'(k_i) * MAX_DIM + 32'(j_i));
  assign wdata   = ELEM_WIDTH'(element_value_i);

  // operand stores
  mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.issue),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.issue),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // a finished sum cannot enter a full output register that is not being drained
  assign stall    = s2_valid_q && s2_last_q && out_valid_q && !out_ready_i;
  assign out_load = s2_valid_q && s2_last_q && !stall;

  // accumulate modulo the result width
  assign acc_sum = (s2_first_q ? '0 : acc_q) + RESULT_W'(prod_q);

  // pipeline and output valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!stall) begin
        s1_valid_q <= cmd_i.issue;
        s2_valid_q <= s1_valid_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      row_q <= row_index_i;
    end
    if (!stall) begin
      s1_first_q    <= cmd_i.first_k;
      s1_last_q     <= cmd_i.last_k;
      s1_row_last_q <= cmd_i.row_last;
      s1_col_q      <= IDX_FIELD_W'(j_i);
      s2_first_q    <= s1_first_q;
      s2_last_q     <= s1_last_q;
      s2_row_last_q <= s1_row_last_q;
      s2_col_q      <= s1_col_q;
      prod_q        <= $signed(a_rdata) * $signed(b_rdata);
    end
    if (s2_valid_q && !stall) begin
      acc_q <= acc_sum;
    end
    if (out_load) begin
      out_value_q    <= acc_sum;
      out_row_q      <= row_q;
      out_col_q      <= s2_col_q;
      out_row_last_q <= s2_row_last_q;
    end
  end

  assign status_o.stall = stall;
  assign status_o.busy  = s1_valid_q || s2_valid_q;

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign result_row_o   = out_row_q;
  assign result_col_o   = out_col_q;
  assign row_last_o     = out_row_last_q;

endmodule

FILE: rtl/matrix_multiply.sv
// top level of the matrix multiply block
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  input    | in_valid_i/in_ready_o  | opcode_i row_index_i col_index_i element_value_i
//  result   | out_valid_o/out_ready_i| result_value_o result_row_o result_col_o row_last_o
//  config   | cfg_valid_i/cfg_ready_o| cfg_index_i cfg_data_i
//
//  a load writes its store in the cycle it is accepted; the next transaction is accepted right after
//  a compute transaction keeps the input channel busy: one shared multiplier does one
//  multiply-accumulate per cycle unless stalled, each column's sum taking K products, plus pipeline drain
//  the operand stores hold no reset; the config port is always ready
//  a result waiting in the output register stalls the mac pipeline only when the
//  next finished sum needs that register
module matrix_multiply #(
  parameter int unsigned MAX_DIM    = 16,
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [mm_pkg::OPCODE_W-1:0]         opcode_i,
  input  logic [mm_pkg::IDX_FIELD_W-1:0]      row_index_i,
  input  logic [mm_pkg::IDX_FIELD_W-1:0]      col_index_i,
  input  logic signed [mm_pkg::IN_ELEM_W-1:0] element_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [mm_pkg::RESULT_W-1:0]  result_value_o,
  output logic [mm_pkg::IDX_FIELD_W-1:0]      result_row_o,
  output logic [mm_pkg::IDX_FIELD_W-1:0]      result_col_o,
  output logic                                row_last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mm_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [mm_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  import mm_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_DIM);

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [IDX_W-1:0] k_idx, j_idx;

  // sequencer
  mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .k_o         (k_idx),
    .j_o         (j_idx),
    .status_i    (status)
  );

  // stores and mac pipeline
  mm_datapath #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .cmd_i           (cmd),
    .k_i             (k_idx),
    .j_i             (j_idx),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_value_o  (result_value_o),
    .result_row_o    (result_row_o),
    .result_col_o    (result_col_o),
    .row_last_o      (row_last_o)
  );

endmodule

FILE: rtl/mm_checker.sv
// port-level checker for the matrix multiply block and its bind
`include "matrix_multiply_defines.svh"

module mm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic [mm_pkg::OPCODE_W-1:0]         opcode_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [mm_pkg::RESULT_W-1:0]  result_value_o,
  input logic [mm_pkg::IDX_FIELD_W-1:0]      result_col_o,
  input logic                                row_last_o
);

  import mm_pkg::*;

  // a blocked result transaction holds its value and column
  `MM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(result_value_o) && $stable(result_col_o), "result changed while stalled")

  // a pending mid-row result means the row is still being computed
  `MM_ASSERT_IMPL(a_mid_row_busy, out_valid_o && !row_last_o, !in_ready_o, "input ready while row unfinished")

  // loads finish in the cycle they are accepted
  `MM_ASSERT_NEXT(a_load_single, in_valid_i && in_ready_o && (opcode_i == OP_LOAD_A || opcode_i == OP_LOAD_B), in_ready_o, "load held the input channel")

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);

FILE: tb/tb_matrix_multiply.sv
// self-checking testbench of the matrix multiply block: directed table, then random traffic
module tb_matrix_multiply;
  import mm_pkg::*;

  localparam int unsigned MAX_DIM       = 16;
  localparam int unsigned ELEM_WIDTH    = 16;
  localparam int unsigned SETTLE_CYCLES = MAX_DIM * MAX_DIM + 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DIR_ROWS      = 19;
  localparam int unsigned REPORT_MAX    = 10;

  // codes the package leaves unnamed
  localparam logic [OPCODE_W-1:0]    OP_UNUSED  = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  // one input transaction, with typed results where they are obvious
  typedef struct packed {
    logic [OPCODE_W-1:0]    op;
    logic [IDX_FIELD_W-1:0] row;
    logic [IDX_FIELD_W-1:0] col;
    logic [IN_ELEM_W-1:0]   value;
    logic                   typed;
    logic [1:0]             n_typed;
    logic signed [RESULT_W-1:0] c0;
    logic signed [RESULT_W-1:0] c1;
  } stim_t;

  // one element of a result row
  typedef struct packed {
    logic signed [RESULT_W-1:0] value;
    logic [IDX_FIELD_W-1:0]     row;
    logic [IDX_FIELD_W-1:0]     col;
    logic                       last;
  } c_elem_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [OPCODE_W-1:0]           opcode_i;
  logic [IDX_FIELD_W-1:0]        row_index_i;
  logic [IDX_FIELD_W-1:0]        col_index_i;
  logic signed [IN_ELEM_W-1:0]   element_value_i;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [RESULT_W-1:0]    result_value_o;
  logic [IDX_FIELD_W-1:0]        result_row_o;
  logic [IDX_FIELD_W-1:0]        result_col_o;
  logic                          row_last_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [CFG_INDEX_W-1:0]        cfg_index_i;
  logic [CFG_DATA_W-1:0]         cfg_data_i;

  // predictor state: operand stores, written flags and matrix shape
  logic signed [ELEM_WIDTH-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic signed [ELEM_WIDTH-1:0] b_mem [MAX_DIM*MAX_DIM];
  bit                           a_set [MAX_DIM*MAX_DIM];
  bit                           b_set [MAX_DIM*MAX_DIM];
  int unsigned                  dim_rows;
  int unsigned                  dim_inner;
  int unsigned                  dim_cols;

  c_elem_t     c_elem_q [$];
  stim_t       dir_tbl [DIR_ROWS];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;

  always #5 clk_i = ~clk_i;

  matrix_multiply #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_value_o  (result_value_o),
    .result_row_o    (result_row_o),
    .result_col_o    (result_col_o),
    .row_last_o      (row_last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  task automatic flag_mismatch(input string msg);
    if (mismatch_cnt < REPORT_MAX) $display("%s", msg);
    mismatch_cnt++;
  endtask

  // out-of-range dimensions saturate to 1..MAX_DIM
  function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic void apply_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ROWS_A:    dim_rows  = clamp_dim(data);
      CFG_INNER_DIM: dim_inner = clamp_dim(data);
      CFG_COLS_B:    dim_cols  = clamp_dim(data);
      default: ;
    endcase
  endfunction

  // dot products of row i of A with every column of B
  task automatic predict_c_row(input logic [IDX_FIELD_W-1:0] row);
    logic signed [63:0] acc;
    logic signed [63:0] prod;
    c_elem_t            e;
    for (int unsigned j = 0; j < dim_cols; j++) begin
      acc = '0;
      for (int unsigned k = 0; k < dim_inner; k++) begin
        prod = a_mem[row*MAX_DIM + k] * b_mem[k*MAX_DIM + j];
        acc  = acc + prod;
      end
      e.value = acc[RESULT_W-1:0];
      e.row   = row;
      e.col   = j[IDX_FIELD_W-1:0];
      e.last  = (j == dim_cols - 1);
      c_elem_q.push_back(e);
    end
  endtask

  // update the stores and queue the expected elements of an accepted transaction
  task automatic account_item(input stim_t it);
    c_elem_t e;
    case (it.op)
      OP_LOAD_A: begin
        a_mem[it.row*MAX_DIM + it.col] = it.value;
        a_set[it.row*MAX_DIM + it.col] = 1'b1;
      end
      OP_LOAD_B: begin
        b_mem[it.row*MAX_DIM + it.col] = it.value;
        b_set[it.row*MAX_DIM + it.col] = 1'b1;
      end
      default: ;
    endcase
    if (it.typed) begin
      for (int j = 0; j < it.n_typed; j++) begin
        e.value = (j == 0) ? it.c0 : it.c1;
        e.row   = it.row;
        e.col   = j[IDX_FIELD_W-1:0];
        e.last  = (j == it.n_typed - 1);
        c_elem_q.push_back(e);
      end
    end else if (it.op == OP_COMPUTE && it.row < dim_rows) begin
      predict_c_row(it.row);
    end
  endtask

  task automatic send_item(input stim_t it);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= it.op;
    row_index_i     <= it.row;
    col_index_i     <= it.col;
    element_value_i <= it.value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    account_item(it);
  endtask

  // hold the input until every expected element is out and the block is quiet
  task automatic drain_wait();
    in_valid_i <= 1'b0;
    while (c_elem_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_cfg(idx, data);
  endtask

  task automatic program_dims(input logic [CFG_DATA_W-1:0] r,
                              input logic [CFG_DATA_W-1:0] k,
                              input logic [CFG_DATA_W-1:0] n,
                              input bit poke_unused);
    cfg_write(CFG_ROWS_A, r);
    cfg_write(CFG_INNER_DIM, k);
    cfg_write(CFG_COLS_B, n);
    if (poke_unused) cfg_write(CFG_UNUSED, '1);
    cfg_valid_i <= 1'b0;
  endtask

  // element values lean on the extremes
  function automatic logic [IN_ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3:       return 16'h0000;
      default: return IN_ELEM_W'($urandom);
    endcase
  endfunction

  // random traffic: computes of in-range rows are preceded by loads of any operand they still lack
  task automatic run_random(input int unsigned n_items);
    int unsigned counted;
    int unsigned pick;
    bit          found;
    stim_t       it;
    counted = 0;
    while (counted < n_items) begin
      pick     = $urandom_range(0, 99);
      it       = '0;
      it.value = rand_elem();
      it.col   = IDX_FIELD_W'($urandom);
      if (pick < 2) begin
        drain_wait();
      end else if (pick < 45) begin
        it.row = IDX_FIELD_W'($urandom_range(0, dim_rows - 1));
        found  = 1'b0;
        for (int unsigned k = 0; k < dim_inner && !found; k++) begin
          if (!a_set[it.row*MAX_DIM + k]) begin
            found = 1'b1;
            it.op = OP_LOAD_A;
            it.col = k[IDX_FIELD_W-1:0];
          end
        end
        for (int unsigned k = 0; k < dim_inner && !found; k++) begin
          for (int unsigned j = 0; j < dim_cols && !found; j++) begin
            if (!b_set[k*MAX_DIM + j]) begin
              found = 1'b1;
              it.op  = OP_LOAD_B;
              it.row = k[IDX_FIELD_W-1:0];
              it.col = j[IDX_FIELD_W-1:0];
            end
          end
        end
        if (!found) it.op = OP_COMPUTE;
        send_item(it);
        counted++;
      end else if (pick < 88) begin
        it.op = $urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A;
        if ($urandom_range(0, 3) == 0) begin
          it.row = IDX_FIELD_W'($urandom);
        end else if (it.op == OP_LOAD_A) begin
          it.row = IDX_FIELD_W'($urandom_range(0, dim_rows - 1));
          it.col = IDX_FIELD_W'($urandom_range(0, dim_inner - 1));
        end else begin
          it.row = IDX_FIELD_W'($urandom_range(0, dim_inner - 1));
          it.col = IDX_FIELD_W'($urandom_range(0, dim_cols - 1));
        end
        send_item(it);
        counted++;
      end else begin
        // ignored traffic: unused opcode or a row beyond the matrix
        if ($urandom_range(0, 1) && dim_rows < MAX_DIM) begin
          it.op  = OP_COMPUTE;
          it.row = IDX_FIELD_W'($urandom_range(dim_rows, MAX_DIM - 1));
        end else begin
          it.op  = OP_UNUSED;
          it.row = IDX_FIELD_W'($urandom);
        end
        send_item(it);
      end
    end
  endtask

  // result side: check each transaction and stall at random
  always @(posedge clk_i) begin : result_check
    c_elem_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (c_elem_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: value %0d row %0d col %0d last %0b",
                                result_value_o, result_row_o, result_col_o, row_last_o));
      end else begin
        want = c_elem_q.pop_front();
        if (want.value !== result_value_o || want.row !== result_row_o ||
            want.col !== result_col_o || want.last !== row_last_o) begin
          flag_mismatch($sformatf(
            "mismatch: expected value %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
            want.value, want.row, want.col, want.last,
            result_value_o, result_row_o, result_col_o, row_last_o));
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("matrix_multiply test failed");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    opcode_i        = OP_LOAD_A;
    row_index_i     = '0;
    col_index_i     = '0;
    element_value_i = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_ROWS_A;
    cfg_data_i      = '0;
    dim_rows        = DIM_RESET;
    dim_inner       = DIM_RESET;
    dim_cols        = DIM_RESET;
    for (int i = 0; i < MAX_DIM*MAX_DIM; i++) begin
      a_mem[i] = '0;
      b_mem[i] = '0;
      a_set[i] = 1'b0;
      b_set[i] = 1'b0;
    end

    // directed rows: op, row, col, value, typed, count, first, second
    dir_tbl = '{
      '{OP_LOAD_A,  4'd0,  4'd0,  16'h7fff, 1'b1, 2'd0, 36'sd0, 36'sd0},
      '{OP_LOAD_A,  4'd0,  4'd1,  16'h8000, 1'b1, 2'd0, 36'sd0, 36'sd0},
      '{OP_LOAD_B,  4'd0,  4'd0,  16'h8000, 1'b1, 2'd0, 36'sd0, 36'sd0},
      '{OP_LOAD_B,  4'd0,  4'd1,  16'h7fff, 1'b1, 2'd0, 36'sd0, 36'sd0},
      '{OP_LOAD_B,  4'd1,  4'd0,  16'h8000, 1'b1, 2'd0, 36'sd0, 36'sd0},
      '{OP_LOAD_B,  4'd1,  4'd1,  16'h8000, 1'b1, 2'd0, 36'sd0, 36'sd0},
      '{OP_COMPUTE, 4'd0,  4'd0,  16'h0000, 1'b1, 2'd2, 36'sd32768, 36'sd2147418113},
      '{OP_LOAD_A,  4'd1,  4'd0,  16'h0000, 1'b1, 2'd0, 36'sd0, 36'sd0},
      '{OP_LOAD_A,  4'd1,  4'd1,  16'hffff, 1'b1, 2'd0, 36'sd0, 36'sd0},
      '{OP_COMPUTE, 4'd1,  4'd0,  16'h0000, 1'b0, 2'd0, 36'sd0, 36'sd0},
      // rows beyond the matrix emit nothing
      '{OP_COMPUTE, 4'd2,  4'd0,  16'h0000, 1'b1, 2'd0, 36'sd0, 36'sd0},
      '{OP_COMPUTE, 4'd15, 4'd15, 16'hffff, 1'b1, 2'd0, 36'sd0, 36'sd0},
      // unused opcode is dropped
      '{OP_UNUSED,  4'd0,  4'd0,  16'h1234, 1'b1, 2'd0, 36'sd0, 36'sd0},
      '{OP_UNUSED,  4'd15, 4'd15, 16'hffff, 1'b1, 2'd0, 36'sd0, 36'sd0},
      // loads outside the configured shape still land in the stores
      '{OP_LOAD_A,  4'd15, 4'd15, 16'h5555, 1'b1, 2'd0, 36'sd0, 36'sd0},
      '{OP_LOAD_B,  4'd15, 4'd15, 16'haaaa, 1'b1, 2'd0, 36'sd0, 36'sd0},
      '{OP_LOAD_A,  4'd0,  4'd0,  16'h0001, 1'b1, 2'd0, 36'sd0, 36'sd0},
      '{OP_COMPUTE, 4'd0,  4'd15, 16'h7fff, 1'b0, 2'd0, 36'sd0, 36'sd0},
      '{OP_LOAD_B,  4'd0,  4'd15, 16'h0100, 1'b1, 2'd0, 36'sd0, 36'sd0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part, sender 21 and receiver 61 percent idle
    snd_idle_pct = 21;
    rcv_idle_pct = 61;
    program_dims(5'd2, 5'd2, 5'd2, 1'b0);
    foreach (dir_tbl[i]) send_item(dir_tbl[i]);

    // saturated and zero dimensions
    drain_wait();
    program_dims(5'd16, 5'd0, 5'd31, 1'b0);
    run_random(26);

    // single row and column, deepest inner dimension
    drain_wait();
    program_dims(5'd1, 5'd16, 5'd1, 1'b0);
    run_random(40);

    // idling swapped
    snd_idle_pct = 61;
    rcv_idle_pct = 21;
    drain_wait();
    program_dims(5'd17, 5'd3, 5'd5, 1'b0);
    run_random(26);

    drain_wait();
    program_dims(5'd4, 5'd5, 5'd3, 1'b1);
    run_random(24);

    // no idling on either side
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    drain_wait();
    program_dims(CFG_DATA_W'($urandom_range(1, 6)), CFG_DATA_W'($urandom_range(1, 6)),
                 CFG_DATA_W'($urandom_range(1, 6)), 1'b0);
    run_random(24);

    drain_wait();
    if (c_elem_q.size() != 0) begin
      $display("%0d expected results never arrived", c_elem_q.size());
      mismatch_cnt += c_elem_q.size();
    end
    if (mismatch_cnt == 0) begin
      $display("matrix_multiply test passed");
    end else begin
      $display("matrix_multiply test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mm_pkg.sv
rtl/mm_ram.sv
rtl/mm_ctrl.sv
rtl/mm_datapath.sv
rtl/matrix_multiply.sv
rtl/mm_checker.sv
tb/tb_matrix_multiply.sv
